/* hw/rtl/fisd_pkg.sv */
// shared constants, types and controller/datapath bundles for the first-idle-server dispatcher
// no dependencies; imported by fisd_ctrl, fisd_datapath and the top level
package fisd_pkg;

    localparam int NUM_SERVERS    = 8;
    localparam int QUEUE_DEPTH    = 64;
    localparam int DURATION_BITS  = 9;

    localparam int SRV_IDX_BITS   = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int SCAN_BITS      = $clog2(NUM_SERVERS + 1);
    localparam int Q_PTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_LVL_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int RUN_BITS       = 16;
    localparam int TICK_BITS      = 32;
    localparam int SRV_CNT_BITS   = 4;

    localparam int CFG_IDX_BITS   = 1;
    localparam int CFG_DATA_BITS  = 32;

    localparam int IN_TDATA_BITS  = ((DURATION_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 2 * SCAN_BITS + NUM_SERVERS + Q_LVL_BITS + 2 * RUN_BITS + 3;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SERVER_COUNT = 1'b0,
        CFG_MAX_TICKS    = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRAP,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic                    start;
        logic                    step;
        logic [SRV_IDX_BITS-1:0] idx;
        logic                    wrap;
        logic                    emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic                 limit;
        logic [SCAN_BITS-1:0] scan_count;
        logic                 out_free;
    } t_stat;

endpackage

/* hw/rtl/fifo_first_idle_server_dispatcher_core.sv */
// top level of the first-idle-server job dispatcher
// depends on fisd_pkg, fisd_ctrl and fisd_datapath
//
// each input beat is one tick of simulated time and may carry a new job (tuser high)
// with its service duration. the block holds a 64-entry job queue in a memory and a
// countdown per server. on a tick the enabled servers are visited in index order, one
// server per clock: an idle server pulls the queue head, a busy one counts down and goes
// idle at zero. afterwards the no-dispatch streaks are updated and the new job is queued
// (dropped when the queue is full). once max_ticks ticks have run, further ticks change
// nothing and report limit_reached. a tick is accepted, then the enabled servers are
// scanned, then wrap-up updates the streaks and the queue, and the result is loaded into
// the output register once it is free; with no server enabled the scan is skipped, and
// a tick past the limit skips scan and wrap-up. one tick is worked at a time; the result
// sits in an output register so the next beat is taken while it waits. config writes
// (index 0 server_count, index 1 max_ticks) are taken in any cycle and must only be
// issued while no tick is in flight
module fifo_first_idle_server_dispatcher_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input stream
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [fisd_pkg::IN_TDATA_BITS-1:0]   i_s_tdata,   // [8:0] arrival_duration
    input  logic                                 i_s_tuser,   // [0] arrival_valid
    // result stream
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [3:0] assigned_count, [11:4] assigned_mask, [15:12] active_count,
    // [22:16] queue_level, [38:23] idle_streak, [54:39] longest_streak,
    // [55] arrival_dropped, [56] limit_reached, [57] all_done, rest zero
    output logic [fisd_pkg::OUT_TDATA_BITS-1:0]  o_m_tdata,
    // config write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  fisd_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [fisd_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import fisd_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer: one beat in, scan, wrap-up, result out
    fisd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // servers, queue, counters and output register
    fisd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

/* hw/rtl/fisd_ctrl.sv */
// tick sequencer for the dispatcher: accept, per-server scan, wrap-up, result hand-off
// depends on fisd_pkg; drives fisd_datapath through t_cmd and reads t_stat
module fisd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  fisd_pkg::t_stat i_stat,
    output fisd_pkg::t_cmd  o_cmd
);
    import fisd_pkg::*;

    t_state                  r_state;
    t_state                  n_state;
    logic [SRV_IDX_BITS-1:0] r_idx;
    logic [SRV_IDX_BITS-1:0] n_idx;
    logic                    w_accept;
    logic                    w_last;

    assign w_accept = (r_state == ST_IDLE) && i_s_tvalid;
    assign w_last   = ((SCAN_BITS'(r_idx) + SCAN_BITS'(1)) >= i_stat.scan_count);

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (w_accept) begin
                    if (i_stat.limit) begin
                        n_state = ST_EMIT;
                    end else if (i_stat.scan_count == '0) begin
                        n_state = ST_WRAP;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (w_last) begin
                    n_state = ST_WRAP;
                end else begin
                    n_idx = r_idx + SRV_IDX_BITS'(1);
                end
            end
            ST_WRAP: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        o_cmd.idx  = r_idx;
        case (r_state)
            ST_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.start = i_s_tvalid;
            end
            ST_SCAN: begin
                o_cmd.step = 1'b1;
            end
            ST_WRAP: begin
                o_cmd.wrap = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

/* hw/rtl/fisd_datapath.sv */
// dispatcher datapath: config registers, server countdowns, job queue memory,
// streak counters and the output register; depends on fisd_pkg, steered by fisd_ctrl
module fisd_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  fisd_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [fisd_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic [fisd_pkg::IN_TDATA_BITS-1:0]   i_s_tdata,
    input  logic                                 i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [fisd_pkg::OUT_TDATA_BITS-1:0]  o_m_tdata,
    input  fisd_pkg::t_cmd                       i_cmd,
    output fisd_pkg::t_stat                      o_stat
);
    import fisd_pkg::*;

    // configuration
    logic [SRV_CNT_BITS-1:0]   r_server_count;
    logic [TICK_BITS-1:0]      r_max_ticks;

    // servers
    logic [DURATION_BITS-1:0]  r_cd [NUM_SERVERS];
    logic [NUM_SERVERS-1:0]    r_busy;
    logic [NUM_SERVERS-1:0]    n_busy;
    logic                      w_cd_we;
    logic [DURATION_BITS-1:0]  w_cd_val;

    // job queue
    logic [DURATION_BITS-1:0]  r_mem [QUEUE_DEPTH];
    logic [DURATION_BITS-1:0]  r_rd_data;
    logic [Q_PTR_BITS-1:0]     r_head;
    logic [Q_PTR_BITS-1:0]     n_head;
    logic [Q_PTR_BITS-1:0]     r_tail;
    logic [Q_PTR_BITS-1:0]     n_tail;
    logic [Q_LVL_BITS-1:0]     r_level;
    logic [Q_LVL_BITS-1:0]     n_level;
    logic                      w_push;

    // tick bookkeeping
    logic [RUN_BITS-1:0]       r_run;
    logic [RUN_BITS-1:0]       n_run;
    logic [RUN_BITS-1:0]       r_longest;
    logic [RUN_BITS-1:0]       n_longest;
    logic [TICK_BITS-1:0]      r_elapsed;
    logic [TICK_BITS-1:0]      n_elapsed;
    logic                      w_limit;

    // per-tick item and result accumulators
    logic                      r_arrive;
    logic                      n_arrive;
    logic [DURATION_BITS-1:0]  r_dur;
    logic [DURATION_BITS-1:0]  n_dur;
    logic [SCAN_BITS-1:0]      r_assigned;
    logic [SCAN_BITS-1:0]      n_assigned;
    logic [NUM_SERVERS-1:0]    r_mask;
    logic [NUM_SERVERS-1:0]    n_mask;
    logic [SCAN_BITS-1:0]      r_active;
    logic [SCAN_BITS-1:0]      n_active;
    logic                      r_dropped;
    logic                      n_dropped;
    logic                      r_limit;
    logic                      n_limit;

    // output register
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic [OUT_TDATA_BITS-1:0] r_out_data;
    logic [OUT_TDATA_BITS-1:0] n_out_data;
    logic                      w_all_done;

    function automatic logic [Q_PTR_BITS-1:0] ptr_inc(input logic [Q_PTR_BITS-1:0] p);
        ptr_inc = (p == Q_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + Q_PTR_BITS'(1);
    endfunction

    assign o_cfg_ready = 1'b1;
    assign w_limit     = (r_elapsed >= r_max_ticks);
    assign w_all_done  = (r_level == '0) && (r_busy == '0);

    assign o_stat.limit      = w_limit;
    assign o_stat.scan_count = (r_server_count > SRV_CNT_BITS'(NUM_SERVERS))
                             ? SCAN_BITS'(NUM_SERVERS) : SCAN_BITS'(r_server_count);
    assign o_stat.out_free   = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        n_busy      = r_busy;
        w_cd_we     = 1'b0;
        w_cd_val    = '0;
        n_head      = r_head;
        n_tail      = r_tail;
        n_level     = r_level;
        w_push      = 1'b0;
        n_run       = r_run;
        n_longest   = r_longest;
        n_elapsed   = r_elapsed;
        n_arrive    = r_arrive;
        n_dur       = r_dur;
        n_assigned  = r_assigned;
        n_mask      = r_mask;
        n_active    = r_active;
        n_dropped   = r_dropped;
        n_limit     = r_limit;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (i_cmd.start) begin
            n_arrive   = i_s_tuser;
            n_dur      = i_s_tdata[DURATION_BITS-1:0];
            n_assigned = '0;
            n_mask     = '0;
            n_active   = '0;
            n_limit    = w_limit;
            n_dropped  = i_s_tuser && w_limit;
        end

        if (i_cmd.step) begin
            if (r_busy[i_cmd.idx]) begin
                n_active = r_active + SCAN_BITS'(1);
                w_cd_we  = 1'b1;
                if (r_cd[i_cmd.idx] <= DURATION_BITS'(1)) begin
                    n_busy[i_cmd.idx] = 1'b0;
                    w_cd_val          = '0;
                end else begin
                    w_cd_val = r_cd[i_cmd.idx] - DURATION_BITS'(1);
                end
            end else if (r_level != '0) begin
                // idle server takes the queue head
                w_cd_we           = 1'b1;
                w_cd_val          = r_rd_data;
                n_busy[i_cmd.idx] = 1'b1;
                n_head            = ptr_inc(r_head);
                n_level           = r_level - Q_LVL_BITS'(1);
                n_assigned        = r_assigned + SCAN_BITS'(1);
                n_mask[i_cmd.idx] = 1'b1;
            end
        end

        if (i_cmd.wrap) begin
            if (r_assigned == '0) begin
                if (r_run != '1) begin
                    n_run = r_run + RUN_BITS'(1);
                end
            end else begin
                n_run = '0;
            end
            if (r_longest < n_run) begin
                n_longest = n_run;
            end
            if (r_arrive) begin
                if (r_level >= Q_LVL_BITS'(QUEUE_DEPTH)) begin
                    n_dropped = 1'b1;
                end else begin
                    w_push  = 1'b1;
                    n_tail  = ptr_inc(r_tail);
                    n_level = r_level + Q_LVL_BITS'(1);
                end
            end
            n_elapsed = r_elapsed + TICK_BITS'(1);
        end

        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_out_data  = {{(OUT_TDATA_BITS - OUT_FIELD_BITS){1'b0}},
                           w_all_done, r_limit, r_dropped, r_longest, r_run,
                           r_level, r_active, r_mask, r_assigned};
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // queue memory, read port always looks at the next head
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_tail] <= r_dur;
        end
        if (w_push && (r_tail == n_head)) begin
            r_rd_data <= r_dur;
        end else begin
            r_rd_data <= r_mem[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cd_we) begin
            r_cd[i_cmd.idx] <= w_cd_val;
        end
        r_arrive   <= n_arrive;
        r_dur      <= n_dur;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_count <= SRV_CNT_BITS'(NUM_SERVERS);
            r_max_ticks    <= '1;
            r_busy         <= '0;
            r_head         <= '0;
            r_tail         <= '0;
            r_level        <= '0;
            r_run          <= '0;
            r_longest      <= '0;
            r_elapsed      <= '0;
            r_assigned     <= '0;
            r_mask         <= '0;
            r_active       <= '0;
            r_dropped      <= 1'b0;
            r_limit        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SERVER_COUNT: r_server_count <= i_cfg_data[SRV_CNT_BITS-1:0];
                    CFG_MAX_TICKS:    r_max_ticks    <= i_cfg_data[TICK_BITS-1:0];
                    default:          r_max_ticks    <= r_max_ticks;
                endcase
            end
            r_busy      <= n_busy;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_level     <= n_level;
            r_run       <= n_run;
            r_longest   <= n_longest;
            r_elapsed   <= n_elapsed;
            r_assigned  <= n_assigned;
            r_mask      <= n_mask;
            r_active    <= n_active;
            r_dropped   <= n_dropped;
            r_limit     <= n_limit;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= Q_LVL_BITS'(QUEUE_DEPTH))
        else $error("queue level above depth");

    a_mask_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_mask) == int'(r_assigned))
        else $error("assigned mask and count disagree");

    a_server_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_assigned) + int'(r_active)) <= NUM_SERVERS)
        else $error("more servers touched than exist");

    // the level checked is the one seen at wrap-up, before the push
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wrap && r_arrive && !r_limit) |=>
            (r_dropped == ($past(r_level) == Q_LVL_BITS'(QUEUE_DEPTH))))
        else $error("drop flag does not match full queue");
`endif

endmodule

/* tb/fifo_first_idle_server_dispatcher_core_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for the first-idle-server job dispatcher core
// depends on fisd_pkg and fifo_first_idle_server_dispatcher_core; carries its own dispatch predictor
module fifo_first_idle_server_dispatcher_core_tb;

    import fisd_pkg::*;

    localparam int LIMIT_CYCLES = 200_000;
    localparam int SETTLE_CLKS  = 16;       // margin over a full tick with all servers enabled
    localparam int MAX_SHOWN    = 40;       // mismatch lines printed before going quiet
    localparam int N_DIR        = 25;

    // one result beat, lowest field last so it lands in the lowest bits
    typedef struct packed {
        logic                     all_done;
        logic                     limit_reached;
        logic                     arrival_dropped;
        logic [RUN_BITS-1:0]      longest_streak;
        logic [RUN_BITS-1:0]      idle_streak;
        logic [Q_LVL_BITS-1:0]    queue_level;
        logic [SCAN_BITS-1:0]     active_count;
        logic [NUM_SERVERS-1:0]   assigned_mask;
        logic [SCAN_BITS-1:0]     assigned_count;
    } tick_result_t;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_SET_SERVERS,
        OP_SET_LIMIT
    } dir_op_t;

    typedef struct {
        dir_op_t      op;
        logic         arrive;
        logic [31:0]  value;    // duration for a tick, register data for a write
        logic         typed;    // expected result written out by hand
        tick_result_t want;
    } dir_row_t;

    // dut ports
    logic                      i_clk;
    logic                      i_rst_n     = 1'b0;
    logic                      i_s_tvalid  = 1'b0;
    logic                      o_s_tready;
    logic [IN_TDATA_BITS-1:0]  i_s_tdata   = '0;    // [8:0] arrival_duration
    logic                      i_s_tuser   = 1'b0;  // [0] arrival_valid
    logic                      o_m_tvalid;
    logic                      i_m_tready  = 1'b0;
    // [3:0] assigned_count, [11:4] assigned_mask, [15:12] active_count, [22:16] queue_level,
    // [38:23] idle_streak, [54:39] longest_streak, [55] arrival_dropped, [56] limit_reached,
    // [57] all_done, rest zero
    logic [OUT_TDATA_BITS-1:0] o_m_tdata;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    t_cfg_idx                  i_cfg_index = CFG_SERVER_COUNT;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data  = '0;

    // predictor state, mirrors the block from reset
    logic [DURATION_BITS-1:0]  srv_left [NUM_SERVERS];
    logic [NUM_SERVERS-1:0]    srv_busy      = '0;
    logic [DURATION_BITS-1:0]  job_queue [$];
    logic [RUN_BITS-1:0]       quiet_run     = '0;
    logic [RUN_BITS-1:0]       longest_quiet = '0;
    logic [TICK_BITS-1:0]      ticks_run     = '0;
    logic [SRV_CNT_BITS-1:0]   servers_on    = 4'd8;
    logic [TICK_BITS-1:0]      tick_limit    = 32'hFFFF_FFFF;

    tick_result_t pending_results [$];
    dir_row_t     dir_rows [N_DIR];

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int n_err = 0;
    int n_ticks = 0;
    int n_jobs = 0;
    int n_drops = 0;
    int n_limited = 0;
    int cycle_count = 0;

    fifo_first_idle_server_dispatcher_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        for (int k = 0; k < NUM_SERVERS; k++) srv_left[k] = '0;
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, pending_results.size());
            $display("[fifo_first_idle_server_dispatcher_core] ERROR");
            $finish;
        end
    end

    // receiver back-pressure, one draw per clock
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    function automatic tick_result_t mk_res(input int assigned, input int mask, input int active,
                                            input int qlvl, input int idle, input int longest,
                                            input int dropped, input int limit, input int done);
        tick_result_t r;
        r.assigned_count  = SCAN_BITS'(assigned);
        r.assigned_mask   = NUM_SERVERS'(mask);
        r.active_count    = SCAN_BITS'(active);
        r.queue_level     = Q_LVL_BITS'(qlvl);
        r.idle_streak     = RUN_BITS'(idle);
        r.longest_streak  = RUN_BITS'(longest);
        r.arrival_dropped = 1'(dropped);
        r.limit_reached   = 1'(limit);
        r.all_done        = 1'(done);
        return r;
    endfunction

    // one tick of the dispatcher: scan, streaks, then queue the arrival
    function automatic tick_result_t dispatch_tick(input logic arrive,
                                                   input logic [DURATION_BITS-1:0] dur);
        tick_result_t r;
        int n;
        int i;
        r = '0;
        if (ticks_run >= tick_limit) begin
            // past the limit: nothing moves, the arrival is refused
            r.limit_reached   = 1'b1;
            r.arrival_dropped = arrive;
        end else begin
            n = (servers_on > NUM_SERVERS) ? NUM_SERVERS : int'(servers_on);
            for (i = 0; i < n; i++) begin
                if (!srv_busy[i]) begin
                    if (job_queue.size() > 0) begin
                        srv_left[i]         = job_queue.pop_front();
                        srv_busy[i]         = 1'b1;
                        r.assigned_count    = r.assigned_count + 1'b1;
                        r.assigned_mask[i]  = 1'b1;
                    end
                end else begin
                    // busy servers keep counting even once the queue runs dry
                    r.active_count = r.active_count + 1'b1;
                    if (srv_left[i] <= 1) begin
                        srv_left[i] = '0;
                        srv_busy[i] = 1'b0;
                    end else begin
                        srv_left[i] = srv_left[i] - 1'b1;
                    end
                end
            end
            if (r.assigned_count == 0) begin
                if (quiet_run != {RUN_BITS{1'b1}}) quiet_run = quiet_run + 1'b1;
            end else begin
                quiet_run = '0;
            end
            if (longest_quiet < quiet_run) longest_quiet = quiet_run;
            if (arrive) begin
                if (job_queue.size() >= QUEUE_DEPTH) r.arrival_dropped = 1'b1;
                else job_queue.insert(job_queue.size(), dur);
            end
            ticks_run = ticks_run + 1'b1;
        end
        r.queue_level    = Q_LVL_BITS'(job_queue.size());
        r.idle_streak    = quiet_run;
        r.longest_streak = longest_quiet;
        // all servers count here, also those beyond the enabled range
        r.all_done       = (job_queue.size() == 0) && (srv_busy == '0);
        return r;
    endfunction

    // mostly short jobs so servers cycle often, with zero and full-range values mixed in
    function automatic logic [DURATION_BITS-1:0] pick_duration();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5)  return '0;
        if (sel < 70) return DURATION_BITS'($urandom_range(16, 1));
        if (sel < 90) return DURATION_BITS'($urandom_range(100, 17));
        return DURATION_BITS'($urandom_range(511, 0));
    endfunction

    // send one tick beat; typed_want replaces the prediction for hand-written rows
    task automatic push_tick(input logic arrive, input logic [DURATION_BITS-1:0] dur,
                             input logic typed, input tick_result_t typed_want);
        int gap;
        tick_result_t r;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= arrive;
        i_s_tdata  <= IN_TDATA_BITS'(dur);
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        // beat taken at this edge: advance the predictor
        r = dispatch_tick(arrive, dur);
        pending_results.insert(pending_results.size(), typed ? typed_want : r);
        n_ticks++;
        n_jobs    += int'(r.assigned_count);
        n_drops   += int'(r.arrival_dropped);
        n_limited += int'(r.limit_reached);
    endtask

    // stop sending, let every result come back and the block go quiet
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CLKS) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SERVER_COUNT: servers_on = value[SRV_CNT_BITS-1:0];
            CFG_MAX_TICKS:    tick_limit = value;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            n_err++;
            if (n_err <= MAX_SHOWN)
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // result monitor: every accepted beat against the oldest expectation
    always @(posedge i_clk) begin
        tick_result_t want;
        tick_result_t got;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            got = o_m_tdata[$bits(tick_result_t)-1:0];
            if (pending_results.size() == 0) begin
                n_err++;
                if (n_err <= MAX_SHOWN)
                    $display("%0t: result beat %h with nothing expected, expected none",
                             $time, o_m_tdata);
            end else begin
                want = pending_results.pop_front();
                check_field("assigned_count", want.assigned_count, got.assigned_count);
                check_field("assigned_mask", want.assigned_mask, got.assigned_mask);
                check_field("active_count", want.active_count, got.active_count);
                check_field("queue_level", want.queue_level, got.queue_level);
                check_field("idle_streak", want.idle_streak, got.idle_streak);
                check_field("longest_streak", want.longest_streak, got.longest_streak);
                check_field("arrival_dropped", want.arrival_dropped, got.arrival_dropped);
                check_field("limit_reached", want.limit_reached, got.limit_reached);
                check_field("all_done", want.all_done, got.all_done);
                check_field("padding", '0, 32'(o_m_tdata >> $bits(tick_result_t)));
            end
        end
    end

    initial begin
        int phase_servers [8];
        int phase_arrive [8];
        int sel;
        tick_result_t none;

        none = '0;
        phase_servers = '{8, 1, 3, 15, 0, 5, 2, 8};
        phase_arrive  = '{60, 40, 70, 50, 80, 90, 30, 100};

        // directed rows: the opening four are simple enough to write out by hand
        dir_rows = '{
            '{OP_TICK, 1'b0, 32'd0,   1'b1, mk_res(0, 8'h00, 0, 0, 1, 1, 0, 0, 1)},
            '{OP_TICK, 1'b1, 32'd1,   1'b1, mk_res(0, 8'h00, 0, 1, 2, 2, 0, 0, 0)},
            '{OP_TICK, 1'b1, 32'd511, 1'b1, mk_res(1, 8'h01, 0, 1, 0, 2, 0, 0, 0)},
            '{OP_TICK, 1'b0, 32'd511, 1'b1, mk_res(1, 8'h02, 1, 0, 0, 2, 0, 0, 0)},
            '{OP_TICK, 1'b1, 32'd0,   1'b0, none},   // zero-length job
            '{OP_TICK, 1'b1, 32'd2,   1'b0, none},
            '{OP_TICK, 1'b1, 32'd3,   1'b0, none},
            '{OP_TICK, 1'b0, 32'd0,   1'b0, none},
            '{OP_TICK, 1'b0, 32'd0,   1'b0, none},
            '{OP_SET_SERVERS, 1'b0, 32'd0, 1'b0, none},   // no servers scanned
            '{OP_TICK, 1'b1, 32'd5,   1'b0, none},
            '{OP_TICK, 1'b1, 32'h155, 1'b0, none},
            '{OP_SET_SERVERS, 1'b0, 32'd15, 1'b0, none},  // above the server total
            '{OP_TICK, 1'b0, 32'h1FF, 1'b0, none},
            '{OP_TICK, 1'b1, 32'h0AA, 1'b0, none},
            '{OP_SET_SERVERS, 1'b0, 32'd1, 1'b0, none},
            '{OP_TICK, 1'b1, 32'd4,   1'b0, none},
            '{OP_TICK, 1'b0, 32'd0,   1'b0, none},
            '{OP_SET_LIMIT, 1'b0, 32'd0, 1'b0, none},     // limit hit straight away
            '{OP_TICK, 1'b1, 32'd7,   1'b0, none},
            '{OP_TICK, 1'b0, 32'd0,   1'b0, none},
            '{OP_SET_LIMIT, 1'b0, 32'hFFFF_FFFF, 1'b0, none},
            '{OP_SET_SERVERS, 1'b0, 32'd8, 1'b0, none},
            '{OP_TICK, 1'b0, 32'd0,   1'b0, none},
            '{OP_TICK, 1'b1, 32'd9,   1'b0, none}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, no idling
        for (int r = 0; r < N_DIR; r++) begin
            case (dir_rows[r].op)
                OP_TICK:
                    push_tick(dir_rows[r].arrive, dir_rows[r].value[DURATION_BITS-1:0],
                              dir_rows[r].typed, dir_rows[r].want);
                OP_SET_SERVERS: begin
                    drain();
                    write_reg(CFG_SERVER_COUNT, dir_rows[r].value);
                end
                OP_SET_LIMIT: begin
                    drain();
                    write_reg(CFG_MAX_TICKS, dir_rows[r].value);
                end
                default: ;
            endcase
        end

        // random phases, each one starting from a quiet block
        for (int p = 0; p < 8; p++) begin
            drain();
            write_reg(CFG_SERVER_COUNT, phase_servers[p]);
            // phase five runs into a short tick limit, phase six lifts it again
            if (p == 5) write_reg(CFG_MAX_TICKS, ticks_run + 32'd40);
            if (p == 6) write_reg(CFG_MAX_TICKS, 32'hFFFF_FFFF);
            sel = p % 4;
            src_idle_pct  = (sel == 1) ? 63 : (sel == 3) ? 13 : 0;
            snk_stall_pct = (sel == 2) ? 63 : (sel == 3) ? 13 : 0;
            for (int k = 0; k < 125; k++)
                push_tick($urandom_range(99) < phase_arrive[p], pick_duration(), 1'b0, none);
        end

        // all servers on with light traffic: queue drains, current streak restarts
        drain();
        src_idle_pct  = 13;
        snk_stall_pct = 13;
        write_reg(CFG_SERVER_COUNT, 8);
        for (int k = 0; k < 60; k++)
            push_tick($urandom_range(99) < 50, pick_duration(), 1'b0, none);

        drain();

        $display("%0d ticks sent (%0d past the tick limit), %0d jobs dispatched, %0d dropped",
                 n_ticks, n_limited, n_jobs, n_drops);
        $display("server counts 0 to 15, tick limits 0, short and maximum, full queue refusals");
        if (n_err == 0) begin
            $display("[fifo_first_idle_server_dispatcher_core] OK");
        end else begin
            $display("%0d mismatches", n_err);
            $display("[fifo_first_idle_server_dispatcher_core] ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/fisd_pkg.sv
hw/rtl/fisd_ctrl.sv
hw/rtl/fisd_datapath.sv
hw/rtl/fifo_first_idle_server_dispatcher_core.sv
tb/fifo_first_idle_server_dispatcher_core_tb.sv
